// ----- rtl/ocps_pkg.sv -----
// Shared types, constants and the opcode length table for the pad stripper.
// No dependencies; imported by ocps_parser and object_code_pad_stripper.
package ocps_pkg;

  // Kept byte counter default width and the reported total width
  localparam int COUNT_BITS_DEF = 16;
  localparam int TOTAL_W        = 16;

  // Special byte values
  localparam logic [7:0] ESC_BYTE  = 8'hdd;
  localparam logic [7:0] PREFIX_CB = 8'hcb;

  // Parse mode codes
  localparam logic [2:0] MODE_OPCODE  = 3'd0;
  localparam logic [2:0] MODE_OPERAND = 3'd1;
  localparam logic [2:0] MODE_PAD     = 3'd2;
  localparam logic [2:0] MODE_ESC1    = 3'd3;
  localparam logic [2:0] MODE_ESC2    = 3'd4;
  localparam logic [2:0] MODE_LEN_HI  = 3'd5;
  localparam logic [2:0] MODE_LEN_LO  = 3'd6;
  localparam logic [2:0] MODE_RAW     = 3'd7;

  // One result item
  typedef struct packed {
    logic                keep;
    logic [7:0]          out_byte;
    logic                illegal;
    logic [TOTAL_W-1:0]  kept_total;
    logic                block_end;
  } result_t;

  // Instruction length per opcode; zero marks an opcode with no encoding
  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] len;
    len = 2'd1;
    unique case (op) inside
      8'h01, 8'h08, 8'h11, 8'h21, 8'h31,
      8'hc2, 8'hc3, 8'hc4, 8'hca, 8'hcc, 8'hcd,
      8'hd2, 8'hd4, 8'hda, 8'hdc, 8'hea, 8'hfa:
        len = 2'd3;
      8'h06, 8'h0e, 8'h16, 8'h18, 8'h1e,
      8'h20, 8'h26, 8'h28, 8'h2e, 8'h30, 8'h36, 8'h38, 8'h3e,
      8'hc6, 8'hcb, 8'hce, 8'hd6, 8'hde,
      8'he0, 8'he6, 8'he8, 8'hee, 8'hf0, 8'hf6, 8'hf8, 8'hfe:
        len = 2'd2;
      8'hd3, 8'hdb, 8'hdd, 8'he3, 8'he4, 8'heb, 8'hec, 8'hed,
      8'hf4, 8'hfc, 8'hfd:
        len = 2'd0;
      default:
        len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/ocps_parser.sv -----
// Parse state and per-byte step logic of the pad stripper.
// Depends on ocps_pkg (mode codes, op_len table, result_t).
module ocps_parser #(
  parameter int COUNT_BITS = ocps_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        code_byte,
  input  logic              block_last,
  output ocps_pkg::result_t result
);
  import ocps_pkg::*;

  logic [2:0]            parse_mode,   parse_mode_next;
  logic [1:0]            operand_left, operand_left_next;
  logic                  pad_pending,  pad_pending_next;
  logic [7:0]            raw_high,     raw_high_next;
  logic [15:0]           raw_left,     raw_left_next;
  logic [COUNT_BITS-1:0] kept_count,   kept_count_next;

  logic       keep;
  logic       bad;
  logic [1:0] len;
  logic [1:0] ops;
  logic       pad;
  logic [15:0] raw_len;
  logic [COUNT_BITS-1:0] kept_step;
  logic [TOTAL_W-1:0]    total;

  // Decode one byte against the current mode
  always_comb begin
    parse_mode_next   = parse_mode;
    operand_left_next = operand_left;
    pad_pending_next  = pad_pending;
    raw_high_next     = raw_high;
    raw_left_next     = raw_left;
    keep    = 1'b0;
    bad     = 1'b0;
    len     = op_len(code_byte);
    ops     = len - 2'd1;
    pad     = (len == 2'd3) || ((len == 2'd2) && (code_byte != PREFIX_CB));
    raw_len = {raw_high, code_byte};
    unique case (parse_mode)
      MODE_OPCODE: begin
        if (len != 2'd0) begin
          keep              = 1'b1;
          operand_left_next = ops;
          pad_pending_next  = pad;
          if (ops != 2'd0) parse_mode_next = MODE_OPERAND;
          else             parse_mode_next = pad ? MODE_PAD : MODE_OPCODE;
        end else if (code_byte == ESC_BYTE) begin
          parse_mode_next = MODE_ESC1;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_OPERAND: begin
        keep              = 1'b1;
        operand_left_next = operand_left - 2'd1;
        if (operand_left == 2'd1)
          parse_mode_next = pad_pending ? MODE_PAD : MODE_OPCODE;
      end
      MODE_PAD: begin
        pad_pending_next = 1'b0;
        parse_mode_next  = MODE_OPCODE;
      end
      MODE_ESC1, MODE_ESC2: begin
        if (code_byte == ESC_BYTE) begin
          parse_mode_next = (parse_mode == MODE_ESC1) ? MODE_ESC2 : MODE_LEN_HI;
        end else begin
          bad             = 1'b1;
          parse_mode_next = MODE_OPCODE;
        end
      end
      MODE_LEN_HI: begin
        raw_high_next   = code_byte;
        parse_mode_next = MODE_LEN_LO;
      end
      MODE_LEN_LO: begin
        raw_left_next   = raw_len;
        parse_mode_next = (raw_len != 16'd0) ? MODE_RAW : MODE_OPCODE;
      end
      MODE_RAW: begin
        keep          = 1'b1;
        raw_left_next = raw_left - 16'd1;
        if (raw_left == 16'd1) parse_mode_next = MODE_OPCODE;
      end
      default: begin
        parse_mode_next = MODE_OPCODE;
      end
    endcase
  end

  // Saturating count of kept bytes
  assign kept_step = (keep && !(&kept_count)) ? kept_count + 1'b1 : kept_count;

  // Clamp the count to the reported width
  generate
    if (COUNT_BITS > TOTAL_W) begin : g_clamp
      assign total = (|kept_step[COUNT_BITS-1:TOTAL_W]) ? '1 : kept_step[TOTAL_W-1:0];
    end else begin : g_extend
      assign total = TOTAL_W'(kept_step);
    end
  endgenerate

  assign kept_count_next = kept_step;

  // Result for the byte now at the input register
  always_comb begin
    result.keep       = keep;
    result.out_byte   = keep ? code_byte : 8'd0;
    result.illegal    = bad;
    result.kept_total = total;
    result.block_end  = block_last;
  end

  // Advance state; a block end returns every field to reset
  always_ff @(posedge clk) begin
    if (rst || (step && block_last)) begin
      parse_mode   <= MODE_OPCODE;
      operand_left <= '0;
      pad_pending  <= 1'b0;
      raw_high     <= '0;
      raw_left     <= '0;
      kept_count   <= '0;
    end else if (step) begin
      parse_mode   <= parse_mode_next;
      operand_left <= operand_left_next;
      pad_pending  <= pad_pending_next;
      raw_high     <= raw_high_next;
      raw_left     <= raw_left_next;
      kept_count   <= kept_count_next;
    end
  end

endmodule

// ----- rtl/object_code_pad_stripper.sv -----
// Top level of the object code pad stripper: input register, parser, result register.
// Depends on ocps_pkg and ocps_parser.
//
// Takes one byte of a code block per request and returns exactly one result per byte,
// saying whether the byte is kept, flagging illegal opcodes and broken DD DD DD escapes,
// and carrying the running count of kept bytes for the block. Throughput is one byte
// per cycle with full back-to-back streaming while the receiver is ready. Each byte
// passes the input register, then the result register, which it enters once that
// register is free or draining. The combinational opcode length table lookup and mode
// update sit between the two registers. A byte with tlast set ends the block and
// returns all parse state and the kept count to their reset values.
module object_code_pad_stripper #(
  parameter int COUNT_BITS = ocps_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tlast,   // block_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] keep, [8:1] out_byte, [9] illegal,
                                 // [25:10] kept_total, [31:26] zero
  output logic        m_tlast    // block_end
);
  import ocps_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;
  result_t    step_result;
  result_t    res;

  // Move the held byte on when the result register is free or draining
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ocps_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .code_byte  (in_byte),
    .block_last (in_last),
    .result     (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= step_result;
    end
  end

  assign m_tdata = {6'd0, res.kept_total, res.illegal, res.out_byte, res.keep};
  assign m_tlast = res.block_end;

  // A dropped byte reports zero data
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
    else $error("dropped byte carries data");

  // A byte is never both kept and illegal
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
    else $error("kept byte flagged illegal");

  // Input stalls only while a byte is held
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("input stalled with empty register");

  // A new result follows every parser step
  assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("result lost after step");

endmodule

// ----- test/object_code_pad_stripper_tb.sv -----
// Testbench for object_code_pad_stripper: streams code blocks byte by byte and
// checks every result against a scoreboard that tracks the stripper's parse state.
// Depends on ocps_pkg and the RTL of object_code_pad_stripper.
module object_code_pad_stripper_tb;
  import ocps_pkg::*;

  localparam int KEPT_BITS    = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BYTES = 1300;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;

  // Instruction length per opcode, one hex digit each, opcode 0x00 in the top digit
  localparam bit [1023:0] OP_LEN_DIGITS = {
    64'h1311_1121_3111_1121, 64'h1311_1121_2111_1121,
    64'h2311_1121_2111_1121, 64'h2311_1121_2111_1121,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1133_3121_1132_3321, 64'h1130_3121_1130_3021,
    64'h2110_0121_2130_0021, 64'h2111_0121_2131_0021
  };

  typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_style_t;

  typedef struct packed {
    logic        keep;
    logic [7:0]  out_byte;
    logic        illegal;
    logic [15:0] kept_total;
    logic        block_end;
  } strip_out_t;

  function automatic bit [1:0] op_length(input logic [7:0] op);
    bit [3:0] digit;
    int       idx;
    idx   = int'(op);
    digit = OP_LEN_DIGITS[1023 - 4 * idx -: 4];
    return digit[1:0];
  endfunction

  // Tracks the parse state and holds the results still owed by the block
  class strip_scoreboard_t;
    logic [2:0]        mode;
    logic [1:0]        operand_left;
    bit                pad_pending;
    logic [7:0]        raw_high;
    logic [15:0]       raw_left;
    longint unsigned   kept_count;
    strip_out_t        pending_results[$];
    int unsigned       errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      mode         = MODE_OPCODE;
      operand_left = '0;
      pad_pending  = 1'b0;
      raw_high     = '0;
      raw_left     = '0;
      kept_count   = 0;
    endfunction

    // Advance the parser by one accepted byte and queue the result it owes
    function void note_byte(logic [7:0] b, logic last);
      strip_out_t      r;
      bit [1:0]        len;
      longint unsigned kept_max;
      r        = '0;
      kept_max = (64'd1 << KEPT_BITS) - 1;
      case (mode)
        MODE_OPCODE: begin
          len = op_length(b);
          if (len != 2'd0) begin
            r.keep       = 1'b1;
            operand_left = len - 2'd1;
            pad_pending  = (len == 2'd3) || (len == 2'd2 && b != PREFIX_CB);
            if (operand_left != 2'd0) mode = MODE_OPERAND;
            else mode = pad_pending ? MODE_PAD : MODE_OPCODE;
          end else if (b == ESC_BYTE) begin
            mode = MODE_ESC1;
          end else begin
            r.illegal = 1'b1;
          end
        end
        MODE_OPERAND: begin
          r.keep       = 1'b1;
          operand_left = operand_left - 2'd1;
          if (operand_left == 2'd0) mode = pad_pending ? MODE_PAD : MODE_OPCODE;
        end
        MODE_PAD: begin
          pad_pending = 1'b0;
          mode        = MODE_OPCODE;
        end
        MODE_ESC1, MODE_ESC2: begin
          if (b == ESC_BYTE) begin
            mode = (mode == MODE_ESC1) ? MODE_ESC2 : MODE_LEN_HI;
          end else begin
            r.illegal = 1'b1;
            mode      = MODE_OPCODE;
          end
        end
        MODE_LEN_HI: begin
          raw_high = b;
          mode     = MODE_LEN_LO;
        end
        MODE_LEN_LO: begin
          raw_left = {raw_high, b};
          mode     = (raw_left != 16'd0) ? MODE_RAW : MODE_OPCODE;
        end
        default: begin
          r.keep   = 1'b1;
          raw_left = raw_left - 16'd1;
          if (raw_left == 16'd0) mode = MODE_OPCODE;
        end
      endcase
      if (r.keep && kept_count < kept_max) kept_count++;
      r.out_byte   = r.keep ? b : 8'h00;
      r.kept_total = (kept_count > 64'hffff) ? 16'hffff : kept_count[15:0];
      r.block_end  = last;
      pending_results.push_back(r);
      if (last) clear_state();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(logic [31:0] data, logic last);
      strip_out_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: tdata 0x%0h, tlast %0b", data, last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("keep", 16'(want.keep), 16'(data[0]));
      compare_field("out_byte", 16'(want.out_byte), 16'(data[8:1]));
      compare_field("illegal", 16'(want.illegal), 16'(data[9]));
      compare_field("kept_total", want.kept_total, data[25:10]);
      compare_field("block_end", 16'(want.block_end), 16'(last));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  strip_scoreboard_t stripped = new();

  int unsigned burst_left    = 0;
  bit          steady_sender = 1'b0;
  bit          hold_request  = 1'b0;
  int unsigned random_sent   = 0;
  int unsigned cycle_count   = 0;

  object_code_pad_stripper DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Offer one byte, sometimes idling first when a burst runs out, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    stripped.note_byte(b, last);
  endtask

  task automatic send_block(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Build a block of mostly well-formed instructions and raw runs, with some noise
  task automatic random_block();
    logic [7:0]  bytes[$];
    int unsigned units;
    int unsigned pick;
    logic [15:0] run_len;
    logic [7:0]  op;
    bit [1:0]    len;
    units = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    steady_sender = ($urandom_range(0, 4) == 0);
    repeat (units) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        do op = 8'($urandom_range(0, 255)); while (op_length(op) == 2'd0);
        len = op_length(op);
        bytes.push_back(op);
        repeat (int'(len) - 1) bytes.push_back(8'($urandom_range(0, 255)));
        if (len == 2'd3 || (len == 2'd2 && op != PREFIX_CB))
          bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 82) begin
        run_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 6));
        repeat (3) bytes.push_back(ESC_BYTE);
        bytes.push_back(run_len[15:8]);
        bytes.push_back(run_len[7:0]);
        repeat ((run_len < 16'd6) ? int'(run_len) : 6)
          bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        do op = 8'($urandom_range(0, 255));
        while (op_length(op) != 2'd0 || op == ESC_BYTE);
        bytes.push_back(op);
      end else if (pick < 94) begin
        // break the escape after one or two escape bytes
        repeat ($urandom_range(1, 2)) bytes.push_back(ESC_BYTE);
        do op = 8'($urandom_range(0, 255)); while (op == ESC_BYTE);
        bytes.push_back(op);
      end else begin
        bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut some blocks short so the block end lands inside an instruction or a run
    if (bytes.size() > 1 && $urandom_range(0, 4) == 0)
      bytes = bytes[0 : $urandom_range(0, bytes.size() - 2)];
    send_block(bytes);
    random_sent += bytes.size();
  endtask

  // Receiver: switch between ready patterns, and honor a long hold-off request
  initial begin : receiver
    ready_style_t style;
    int unsigned  style_left;
    int unsigned  hold_left;
    int unsigned  tick;
    style      = READY_ALWAYS;
    style_left = 0;
    hold_left  = 0;
    tick       = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 300);
      end
      style_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (style)
          READY_ALWAYS: m_tready <= 1'b1;
          READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
          READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          default:      m_tready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // Check every delivered result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) stripped.check_result(m_tdata, m_tlast);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 3-byte with pad, 2-byte with pad, prefix without pad, illegal opcode,
    // escapes broken after one and two bytes, empty raw run, one-byte raw run,
    // and a block end inside an instruction
    directed = '{8'h01, 8'h34, 8'h12, 8'h00, 8'h06, 8'hff, 8'h55, 8'hcb, 8'h37,
                 8'hd3, 8'hdd, 8'h00, 8'hdd, 8'hdd, 8'h10,
                 8'hdd, 8'hdd, 8'hdd, 8'h00, 8'h00,
                 8'hdd, 8'hdd, 8'hdd, 8'h00, 8'h01, 8'hff, 8'hc3, 8'hff};
    send_block(directed);

    // Raw run with a nonzero high length byte, then opcodes to close the block
    repeat (3) send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (256) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Stall the receiver for a long stretch while requests keep coming
    hold_request = 1'b1;
    while (random_sent < RANDOM_BYTES) random_block();
    s_tvalid <= 1'b0;

    while (stripped.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stripped.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ocps_pkg.sv
rtl/ocps_parser.sv
rtl/object_code_pad_stripper.sv
test/object_code_pad_stripper_tb.sv
